// ===== rtl/core/totp_pkg.sv =====
package totp_pkg;

    localparam int KeyHiWidth  = 64;
    localparam int KeyLoWidth  = 32;
    localparam int TimeWidth   = 64;
    localparam int CodeWidth   = 32;
    localparam int CfgIdxWidth = 2;
    localparam int CfgDatWidth = 64;

    localparam logic [CfgIdxWidth-1:0] CFG_KEY_HI  = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_KEY_MID = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_KEY_LO  = 2'd2;

    localparam logic [31:0] CodeModulus = 32'd1000000;
    localparam logic [5:0]  StepSeconds = 6'd30;

    // ceil(2^26 / 30): exact quotient digit for a 21-bit partial dividend
    localparam logic [21:0] StepRecip = 22'd2236963;
    // floor(2^32 / 1000000): quotient estimate low by at most one
    localparam logic [12:0] CodeRecip = 13'd4294;

    // which 512-bit block the datapath builds next
    typedef enum logic [1:0] {
        BLK_IPAD  = 2'd0,
        BLK_IMSG  = 2'd1,
        BLK_OPAD  = 2'd2,
        BLK_OMSG  = 2'd3
    } blk_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     load;      // latch input beat, start counter division
        logic     div_step;  // one 16-bit digit of time / 30
        logic     win_init;  // set counter for window 1 (counter - 1)
        logic     win_next;  // advance counter by one
        logic     blk_start; // load message schedule for selected block
        blk_sel_t blk;
        logic     h_init;    // load the SHA-1 initial value
        logic     round;     // one SHA-1 round
        logic     h_add;     // fold working vars into chaining value
        logic     save_inner;// keep inner digest
        logic     trunc;     // dynamic truncation into remainder register
        logic     mod_mul;   // quotient estimate by reciprocal
        logic     mod_sub;   // subtract quotient times modulus
        logic     mod_fix;   // final conditional subtract
    } totp_cmd_t;

    typedef struct packed {
        logic well_formed;
        logic match;
    } totp_sts_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

// ===== rtl/core/totp_code_verifier.sv =====
// Channel | Dir | Beat payload (lowest bit first)
// s_      | in  | tdata: unix_seconds[63:0], code_value[95:64], code_well_formed[96]
// m_      | out | tdata: accepted[0], matched_window[2:1]
// cfg_    | in  | cfg_index: register index, cfg_data: register value
// One item at a time: the counter is formed first, then each window runs
// four SHA-1 compressions on the shared round unit, the control states
// and the modulo steps before its result is compared.
// Reset is synchronous and clears key registers and control state.
// A waiting result blocks new input until m_tready takes it.
module totp_code_verifier (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // unix_seconds, code_value, code_well_formed
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // accepted, matched_window
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [totp_pkg::CfgIdxWidth-1:0] cfg_index,
    input  logic [totp_pkg::CfgDatWidth-1:0] cfg_data
);
    import totp_pkg::*;

    logic [KeyHiWidth-1:0] key_hi_reg, key_mid_reg;
    logic [KeyLoWidth-1:0] key_lo_reg;
    totp_cmd_t cmd;
    totp_sts_t sts;
    logic [6:0] round_idx;
    logic       acc;
    logic [1:0] win;

    assign cfg_ready = 1'b1;

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg  <= '0;
            key_mid_reg <= '0;
            key_lo_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_KEY_HI:  key_hi_reg  <= cfg_data;
                CFG_KEY_MID: key_mid_reg <= cfg_data;
                CFG_KEY_LO:  key_lo_reg  <= cfg_data[KeyLoWidth-1:0];
                default: ;
            endcase
        end
    end

    totp_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_accepted(acc), .out_window(win),
        .round_idx, .cmd, .sts
    );

    totp_datapath u_dp (
        .aclk, .aresetn,
        .unix_seconds(s_tdata[63:0]),
        .code_value(s_tdata[95:64]),
        .code_well_formed(s_tdata[96]),
        .key_hi(key_hi_reg), .key_mid(key_mid_reg), .key_lo(key_lo_reg),
        .round_idx, .cmd, .sts
    );

    assign m_tdata = {5'd0, win, acc};

endmodule

// ===== rtl/core/totp_datapath.sv =====
module totp_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [totp_pkg::TimeWidth-1:0] unix_seconds,
    input  logic [totp_pkg::CodeWidth-1:0] code_value,
    input  logic                          code_well_formed,
    input  logic [totp_pkg::KeyHiWidth-1:0] key_hi,
    input  logic [totp_pkg::KeyHiWidth-1:0] key_mid,
    input  logic [totp_pkg::KeyLoWidth-1:0] key_lo,
    input  logic [6:0]                    round_idx,
    input  totp_pkg::totp_cmd_t           cmd,
    output totp_pkg::totp_sts_t           sts
);
    import totp_pkg::*;

    logic [63:0]  time_reg, time_next;     // dividend shifting into quotient
    logic [4:0]   rem_reg, rem_next;       // division remainder, below 30
    logic [63:0]  ctr_reg, ctr_next;
    logic [31:0]  code_reg;
    logic         wf_reg;
    logic [159:0] key;
    logic [511:0] w_reg, w_next;           // 16-word schedule window
    logic [159:0] h_reg, h_next;
    logic [159:0] inner_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  val_reg, val_next;
    logic [11:0]  mq_reg, mq_next;         // quotient estimate of val / 10^6
    logic [511:0] blk;
    logic [31:0]  f, k, t, wnew;
    logic [159:0] mac;
    logic [3:0]   off;
    logic [31:0]  word;
    logic [6:0]   ridx;
    logic [20:0]  dv, dr;
    logic [42:0]  dprod;
    logic [15:0]  dq;
    logic [43:0]  mprod;

    assign key = {key_hi, key_mid, key_lo};
    assign mac = h_reg;
    assign ridx = round_idx;

    // block assembly
    always_comb begin
        unique case (cmd.blk)
            BLK_IPAD: blk = {key, 352'd0} ^ {64{8'h36}};
            BLK_OPAD: blk = {key, 352'd0} ^ {64{8'h5c}};
            BLK_IMSG: blk = {ctr_reg, 8'h80, 376'd0, 64'd576};
            default:  blk = {inner_reg, 8'h80, 280'd0, 64'd672};
        endcase
    end

    // round function
    always_comb begin
        if (ridx < 7'd20) begin
            f = (b_reg & c_reg) | (~b_reg & d_reg); k = 32'h5A827999;
        end else if (ridx < 7'd40) begin
            f = b_reg ^ c_reg ^ d_reg;              k = 32'h6ED9EBA1;
        end else if (ridx < 7'd60) begin
            f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg); k = 32'h8F1BBCDC;
        end else begin
            f = b_reg ^ c_reg ^ d_reg;              k = 32'hCA62C1D6;
        end
        t = rotl(a_reg, 5) + f + e_reg + k + w_reg[511:480];
        wnew = rotl(w_reg[95:64] ^ w_reg[255:224] ^ w_reg[447:416] ^ w_reg[511:480], 1);
    end

    // dynamic truncation
    always_comb begin
        off  = mac[3:0];
        word = mac[159 - 8*off -: 32];
        word[31] = 1'b0;
    end

    // time / 30 one 16-bit digit at a time; quotient digit by reciprocal
    always_comb begin
        dv    = {rem_reg, time_reg[63:48]};
        dprod = {22'd0, dv} * {21'd0, StepRecip};
        dq    = dprod[41:26];
        dr    = dv - {dq, 5'd0} + {4'd0, dq, 1'b0};
        mprod = {13'd0, val_reg[30:0]} * {31'd0, CodeRecip};
    end

    // next-state of datapath registers
    always_comb begin
        time_next = time_reg;
        rem_next  = rem_reg;
        ctr_next  = ctr_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        val_next  = val_reg;
        mq_next   = mq_reg;
        if (cmd.load) begin
            time_next = unix_seconds;
            rem_next  = '0;
        end
        if (cmd.div_step) begin
            // quotient digit enters at the bottom
            rem_next  = dr[4:0];
            time_next = {time_reg[47:0], dq};
        end
        if (cmd.win_init) ctr_next = time_reg - 64'd1;
        if (cmd.win_next) ctr_next = ctr_reg + 64'd1;
        if (cmd.blk_start) w_next = blk;
        else if (cmd.round) w_next = {w_reg[479:0], wnew};
        if (cmd.h_init) h_next = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
        if (cmd.h_add)
            h_next = {h_reg[159:128] + a_reg, h_reg[127:96] + b_reg, h_reg[95:64] + c_reg,
                      h_reg[63:32] + d_reg, h_reg[31:0] + e_reg};
        if (cmd.trunc) val_next = word;
        // modulo: estimate, subtract, then at most one correction
        if (cmd.mod_mul) mq_next = mprod[43:32];
        if (cmd.mod_sub) val_next = val_reg - ({20'd0, mq_reg} * CodeModulus);
        if (cmd.mod_fix) begin
            if (val_reg >= CodeModulus) val_next = val_reg - CodeModulus;
        end
    end

    // registers
    always_ff @(posedge aclk) begin
        time_reg <= time_next;
        rem_reg  <= rem_next;
        ctr_reg  <= ctr_next;
        w_reg    <= w_next;
        h_reg    <= h_next;
        val_reg  <= val_next;
        mq_reg   <= mq_next;
        if (cmd.load) code_reg <= code_value;
        if (!aresetn) wf_reg <= 1'b0;
        else if (cmd.load) wf_reg <= code_well_formed;
        if (cmd.save_inner) inner_reg <= h_reg;
        if (cmd.blk_start) begin
            a_reg <= h_reg[159:128]; b_reg <= h_reg[127:96]; c_reg <= h_reg[95:64];
            d_reg <= h_reg[63:32];   e_reg <= h_reg[31:0];
        end else if (cmd.round) begin
            e_reg <= d_reg; d_reg <= c_reg; c_reg <= rotl(b_reg, 30);
            b_reg <= a_reg; a_reg <= t;
        end
    end

    assign sts.well_formed = wf_reg;
    assign sts.match       = (val_reg == code_reg);

endmodule

// ===== rtl/core/totp_ctrl.sv =====
module totp_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_accepted,
    output logic [1:0]          out_window,
    output logic [6:0]          round_idx,
    output totp_pkg::totp_cmd_t cmd,
    input  totp_pkg::totp_sts_t sts
);
    import totp_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIV   = 9'b000000010,
        S_WIN   = 9'b000000100,
        S_BLK   = 9'b000001000,
        S_ROUND = 9'b000010000,
        S_ADD   = 9'b000100000,
        S_TRUNC = 9'b001000000,
        S_MOD   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;    // division digits, rounds, mod steps
    logic [1:0]  blk_reg, blk_next;
    logic [1:0]  win_reg, win_next;
    logic        acc_reg, acc_next;
    logic [1:0]  mw_reg, mw_next;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_DONE);
    assign out_accepted = acc_reg;
    assign out_window   = mw_reg;
    assign round_idx    = cnt_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        blk_next   = blk_reg;
        win_next   = win_reg;
        acc_next   = acc_reg;
        mw_next    = mw_reg;
        cmd        = '0;
        cmd.blk    = blk_sel_t'(blk_reg);
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    acc_next   = 1'b0;
                    mw_next    = 2'd0;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (!sts.well_formed) begin
                    state_next = S_DONE;
                end else begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + 7'd1;
                    if (cnt_reg == 7'd3) begin
                        state_next = S_WIN;
                        win_next   = 2'd1;
                    end
                end
            end
            S_WIN: begin
                if (win_reg == 2'd1) cmd.win_init = 1'b1;
                else                 cmd.win_next = 1'b1;
                cmd.h_init = 1'b1;
                blk_next   = BLK_IPAD;
                state_next = S_BLK;
            end
            S_BLK: begin
                cmd.blk_start = 1'b1;
                cnt_next      = '0;
                state_next    = S_ROUND;
            end
            S_ROUND: begin
                cmd.round = 1'b1;
                cnt_next  = cnt_reg + 7'd1;
                if (cnt_reg == 7'd79) state_next = S_ADD;
            end
            S_ADD: begin
                cmd.h_add = 1'b1;
                unique case (blk_sel_t'(blk_reg))
                    BLK_IPAD: begin blk_next = BLK_IMSG; state_next = S_BLK; end
                    BLK_IMSG: begin
                        blk_next   = BLK_OPAD;
                        state_next = S_TRUNC;  // via save/reinit below
                    end
                    BLK_OPAD: begin blk_next = BLK_OMSG; state_next = S_BLK; end
                    default:  state_next = S_TRUNC;
                endcase
            end
            S_TRUNC: begin
                if (blk_sel_t'(blk_reg) == BLK_OPAD) begin
                    // inner hash done: keep it and restart for outer
                    cmd.save_inner = 1'b1;
                    cmd.h_init     = 1'b1;
                    state_next     = S_BLK;
                end else begin
                    cmd.trunc  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                // estimate, subtract, correct, then compare
                cnt_next    = cnt_reg + 7'd1;
                cmd.mod_mul = (cnt_reg == 7'd0);
                cmd.mod_sub = (cnt_reg == 7'd1);
                cmd.mod_fix = (cnt_reg == 7'd2);
                if (cnt_reg == 7'd3) begin
                    if (sts.match) begin
                        acc_next   = 1'b1;
                        mw_next    = win_reg;
                        state_next = S_DONE;
                    end else if (win_reg == 2'd3) begin
                        state_next = S_DONE;
                    end else begin
                        win_next   = win_reg + 2'd1;
                        state_next = S_WIN;
                    end
                end
            end
            S_DONE: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            blk_reg   <= '0;
            win_reg   <= '0;
            acc_reg   <= 1'b0;
            mw_reg    <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            blk_reg   <= blk_next;
            win_reg   <= win_next;
            acc_reg   <= acc_next;
            mw_reg    <= mw_next;
        end
    end

    a_acc_window: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_accepted == (out_window != 2'd0)))
        else $error("accept flag and window disagree");
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.round && cmd.blk_start))
        else $error("round during block load");
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("input and output both open");
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid && $stable(out_window))
        else $error("result dropped while stalled");

endmodule
